@@ hw/rtl/block_table_allocator_unit_assert.svh @@
// Assertion macros for the block table allocator.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef BLOCK_TABLE_ALLOCATOR_UNIT_ASSERT_SVH
`define BLOCK_TABLE_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Condition holds at every edge outside reset
`define BTA_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");
// Consequent holds in the cycle after the antecedent
`define BTA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BTA_ASSERT(label, cond)
`define BTA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/bta_pkg.sv @@
// Shared types, constants and codes for the block table allocator.
// No dependencies; imported by bta_table, block_table_allocator_unit and tb_top.
package bta_pkg;

   // Pool geometry (block size must be a power of two)
   localparam int BLOCK_BYTES = 32;
   localparam int NUM_BLOCKS  = 256;
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

   // Table address, scan index (holds up to 2*NUM_BLOCKS-1), entry width
   localparam int IDX_W   = $clog2(NUM_BLOCKS);
   localparam int SCAN_W  = IDX_W + 1;
   localparam int ENTRY_W = $clog2(NUM_BLOCKS + 1);

   // Field widths
   localparam int CMD_W   = 2;
   localparam int SIZE_W  = 16;
   localparam int OFS_W   = 16;
   localparam int STAT_W  = 2;
   localparam int OFF_W   = 13;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FAIL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [SIZE_W-1:0] size_bytes;
      logic [OFS_W-1:0]  free_offset;
      logic              free_null;
   } req_word_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [OFF_W-1:0]  alloc_offset;
   } rsp_word_type;

   // Control from the sequencer to the table
   typedef struct packed {
      logic               clear;
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [ENTRY_W-1:0] wr_data;
   } tbl_ctl_type;

endpackage

@@ hw/rtl/block_table_allocator_unit.sv @@
// First-fit block allocator over a pool of NUM_BLOCKS blocks of BLOCK_BYTES
// bytes, tracked by a block table in on-chip memory. One request word is
// handled at a time and gives one response word. Allocate reads each table
// entry the scan visits (the table read is registered and the next address
// depends on the entry read), then marks each block of the run found. Free
// reads the entry of the freed block and clears each block of its run, unless
// it is ignored. The response register lets the next request enter while a
// response is still stalled.
// Depends on bta_pkg, bta_table and block_table_allocator_unit_assert.svh.
`include "block_table_allocator_unit_assert.svh"

module block_table_allocator_unit
   import bta_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_SCAN_RD = 8'b0000_0010,
      S_SCAN_EV = 8'b0000_0100,
      S_MARK    = 8'b0000_1000,
      S_FREE_RD = 8'b0001_0000,
      S_FREE_EV = 8'b0010_0000,
      S_ZERO    = 8'b0100_0000,
      S_RESP    = 8'b1000_0000
   } state_type;

   localparam int RND_W = SIZE_W + BLOCK_SHIFT + 1;

   state_type          state_ff,  state_in;
   logic [ENTRY_W-1:0] need_ff,   need_in;
   logic [ENTRY_W-1:0] run_ff,    run_in;
   logic [SCAN_W-1:0]  idx_ff,    idx_in;
   logic [SCAN_W-1:0]  cnt_ff,    cnt_in;
   logic [SCAN_W-1:0]  end_ff,    end_in;
   logic [IDX_W-1:0]   start_ff,  start_in;
   logic               first_ff,  first_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff,  rsp_word_in;

   tbl_ctl_type        tbl_ctl;
   logic [ENTRY_W-1:0] entry;
   logic               req_accept;
   logic               rsp_load;
   logic [RND_W-1:0]   need_full;
   logic [OFS_W-1:0]   free_blk;
   logic [SCAN_W:0]    idx_skip;
   logic [SCAN_W-1:0]  idx_next;
   logic [SCAN_W:0]    run_end;
   logic [IDX_W+BLOCK_SHIFT-1:0] byte_off;

   bta_table u_table (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tbl_ctl),
      .rd_data (entry)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall);

   // Request decode: blocks needed, block index of a free
   assign need_full = (RND_W'(req_word.size_bytes) + RND_W'(BLOCK_BYTES - 1)) >> BLOCK_SHIFT;
   assign free_blk  = req_word.free_offset >> BLOCK_SHIFT;

   // Scan and free arithmetic
   assign idx_skip = (SCAN_W+1)'(idx_ff) + (SCAN_W+1)'(entry);
   assign idx_next = idx_ff + SCAN_W'(1);
   assign run_end  = (SCAN_W+1)'(idx_ff) + (SCAN_W+1)'(entry);
   assign byte_off = {start_ff, {BLOCK_SHIFT{1'b0}}};

   // Table access
   always_comb begin
      tbl_ctl         = '0;
      tbl_ctl.clear   = req_accept && (req_word.command == CMD_CLEAR);
      tbl_ctl.rd_en   = (state_ff == S_SCAN_RD) || (state_ff == S_FREE_RD);
      tbl_ctl.rd_addr = idx_ff[IDX_W-1:0];
      tbl_ctl.wr_en   = (state_ff == S_MARK) || (state_ff == S_ZERO);
      tbl_ctl.wr_addr = cnt_ff[IDX_W-1:0];
      if (state_ff == S_MARK) begin
         tbl_ctl.wr_data = first_ff ? need_ff : ENTRY_W'(1);
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      need_in   = need_ff;
      run_in    = run_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      end_in    = end_ff;
      start_in  = start_ff;
      first_in  = first_ff;
      status_in = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               status_in = ST_DONE;
               start_in  = '0;
               state_in  = S_RESP;
               unique case (req_word.command)
                  CMD_ALLOC: begin
                     if (need_full == '0 || need_full > RND_W'(NUM_BLOCKS)) begin
                        status_in = ST_FAIL;
                     end else begin
                        need_in  = ENTRY_W'(need_full);
                        run_in   = '0;
                        idx_in   = '0;
                        state_in = S_SCAN_RD;
                     end
                  end
                  CMD_FREE: begin
                     if (req_word.free_null || free_blk >= OFS_W'(NUM_BLOCKS)) begin
                        status_in = ST_IGNORED;
                     end else begin
                        idx_in   = SCAN_W'(free_blk);
                        state_in = S_FREE_RD;
                     end
                  end
                  default: begin
                     // clear is done by the table; unused code does nothing
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            if (entry == '0) begin
               if (ENTRY_W'(run_ff + ENTRY_W'(1)) == need_ff) begin
                  // run found, ending at idx
                  start_in = IDX_W'(idx_next - SCAN_W'(need_ff));
                  cnt_in   = SCAN_W'(IDX_W'(idx_next - SCAN_W'(need_ff)));
                  end_in   = idx_next;
                  first_in = 1'b1;
                  state_in = S_MARK;
               end else begin
                  run_in = run_ff + ENTRY_W'(1);
                  idx_in = idx_next;
                  if (idx_next >= SCAN_W'(NUM_BLOCKS)) begin
                     status_in = ST_FAIL;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
            end else begin
               // allocated run: skip over it
               run_in = '0;
               idx_in = SCAN_W'(idx_skip);
               if (idx_skip >= (SCAN_W+1)'(NUM_BLOCKS)) begin
                  status_in = ST_FAIL;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_MARK: begin
            first_in = 1'b0;
            cnt_in   = cnt_ff + SCAN_W'(1);
            if (cnt_ff + SCAN_W'(1) >= end_ff) begin
               state_in = S_RESP;
            end
         end
         S_FREE_RD: begin
            state_in = S_FREE_EV;
         end
         S_FREE_EV: begin
            cnt_in = idx_ff;
            if (run_end >= (SCAN_W+1)'(NUM_BLOCKS)) begin
               end_in = SCAN_W'(NUM_BLOCKS);
            end else begin
               end_in = SCAN_W'(run_end);
            end
            state_in = (entry == '0) ? S_RESP : S_ZERO;
         end
         S_ZERO: begin
            cnt_in = cnt_ff + SCAN_W'(1);
            if (cnt_ff + SCAN_W'(1) >= end_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in        = 1'b1;
         rsp_word_in.status  = status_ff;
         rsp_word_in.alloc_offset = (status_ff == ST_DONE) ? OFF_W'(byte_off) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         need_ff      <= '0;
         run_ff       <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         need_ff      <= need_in;
         run_ff       <= run_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      end_ff      <= end_in;
      start_ff    <= start_in;
      status_ff   <= status_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Checks
   `BTA_ASSERT_NEXT(a_accept_leaves_idle, req_accept, state_ff != S_IDLE)
   `BTA_ASSERT(a_write_in_range, !tbl_ctl.wr_en || cnt_ff < SCAN_W'(NUM_BLOCKS))
   `BTA_ASSERT(a_run_bounded, run_ff <= need_ff)
   `BTA_ASSERT_NEXT(a_rsp_from_resp, !rsp_valid_ff && !(state_ff == S_RESP), !rsp_valid_ff)

endmodule

@@ hw/rtl/bta_table.sv @@
// Block table storage: one-port-write, one-port-read memory with per-entry
// valid bits so a reset or clear empties the table at once. Uses bta_pkg.
module bta_table
   import bta_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  tbl_ctl_type        ctl,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0]    table_mem [NUM_BLOCKS];
   logic [ENTRY_W-1:0]    rd_raw_ff;
   logic                  rd_valid_ff;
   logic [NUM_BLOCKS-1:0] valid_ff;
   logic [NUM_BLOCKS-1:0] valid_in;

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         table_mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_raw_ff   <= table_mem[ctl.rd_addr];
         rd_valid_ff <= valid_ff[ctl.rd_addr];
      end
   end

   // Valid bits: clear wipes all, a write marks its entry
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Never-written entries read as free
   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

@@ dv/tb_top.sv @@
// Testbench for block_table_allocator_unit: directed and random request words,
// checked against a first-fit block table predictor held in a scoreboard class.
// Depends on bta_pkg and the block_table_allocator_unit RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bta_pkg::*;

   localparam int RANDOM_WORDS = 1700;
   localparam int DRAIN_CYCLES = 3 * NUM_BLOCKS + 20;
   localparam int CYCLE_LIMIT  = 5_000_000;

   // Predicts the response word for each accepted request and checks the DUT
   class alloc_scoreboard;
      logic [ENTRY_W-1:0] blk_table [NUM_BLOCKS];
      bit                 live_start [NUM_BLOCKS];
      rsp_word_type       pending_rsp [$];
      int                 errors;

      function new();
         errors = 0;
         wipe_table();
      endfunction

      function void wipe_table();
         for (int k = 0; k < NUM_BLOCKS; k++) begin
            blk_table[k]  = '0;
            live_start[k] = 1'b0;
         end
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type r;
         int need, idx, run, start, len;
         r.status       = ST_DONE;
         r.alloc_offset = '0;
         case (w.command)
            CMD_CLEAR: begin
               wipe_table();
            end
            CMD_ALLOC: begin
               need = (int'(w.size_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
               idx  = 0;
               run  = 0;
               if (need == 0 || need > NUM_BLOCKS) begin
                  r.status = ST_FAIL;
               end else begin
                  // first-fit scan; used entries skip ahead by their value
                  while (idx < NUM_BLOCKS) begin
                     if (blk_table[idx] == '0) begin
                        run++;
                        if (run == need) break;
                        idx++;
                     end else begin
                        run = 0;
                        idx += int'(blk_table[idx]);
                     end
                  end
                  if (idx >= NUM_BLOCKS) begin
                     r.status = ST_FAIL;
                  end else begin
                     start = idx + 1 - need;
                     blk_table[start]  = ENTRY_W'(need);
                     live_start[start] = 1'b1;
                     for (int k = start + 1; k < start + need; k++) blk_table[k] = ENTRY_W'(1);
                     r.alloc_offset = OFF_W'(start * BLOCK_BYTES);
                  end
               end
            end
            CMD_FREE: begin
               idx = int'(w.free_offset) / BLOCK_BYTES;
               if (w.free_null || idx >= NUM_BLOCKS) begin
                  r.status = ST_IGNORED;
               end else begin
                  len = int'(blk_table[idx]);
                  for (int k = idx; k < idx + len && k < NUM_BLOCKS; k++) begin
                     blk_table[k]  = '0;
                     live_start[k] = 1'b0;
                  end
               end
            end
            default: ;  // unused command: no effect, status done
         endcase
         pending_rsp.push_back(r);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type exp_rsp;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected response word status=%0d offset=%0d",
                     $time, got.status, got.alloc_offset);
            return;
         end
         exp_rsp = pending_rsp.pop_front();
         if (got.status !== exp_rsp.status) begin
            errors++;
            $display("%0t: status mismatch expected=%0d actual=%0d",
                     $time, exp_rsp.status, got.status);
         end
         if (got.alloc_offset !== exp_rsp.alloc_offset) begin
            errors++;
            $display("%0t: alloc_offset mismatch expected=%0d actual=%0d",
                     $time, exp_rsp.alloc_offset, got.alloc_offset);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   alloc_scoreboard sb = new();
   int burst_left  = 0;
   int stall_phase = 0;
   int stall_mode  = 0;
   int cycle_count = 0;

   block_table_allocator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response stall: phases of no stall, light random and heavy stall
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_mode  <= $urandom_range(0, 2);
         stall_phase <= $urandom_range(20, 300);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 99) < 30);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_word);
   end

   function automatic req_word_type make_word(logic [CMD_W-1:0] cmd, int size, int ofs,
                                              bit is_null);
      req_word_type w;
      w.command     = cmd;
      w.size_bytes  = SIZE_W'(size);
      w.free_offset = OFS_W'(ofs);
      w.free_null   = is_null;
      return w;
   endfunction

   // Drive one request word in bursts with random gaps; note it on acceptance
   task automatic send_word(input req_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_word  <= w;
      req_valid <= 1'b1;
      burst_left--;
      do @(posedge clock); while (req_stall);
      sb.note_request(w);
   endtask

   task automatic run_directed();
      send_word(make_word(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1));
      send_word(make_word(CMD_ALLOC, 0, 0, 1'b0));           // zero size
      send_word(make_word(CMD_ALLOC, 1, 16'hFFFF, 1'b1));
      send_word(make_word(CMD_ALLOC, 32, 0, 1'b0));
      send_word(make_word(CMD_ALLOC, 33, 0, 1'b0));          // rounds to two blocks
      send_word(make_word(CMD_ALLOC, 16'hFFFF, 0, 1'b0));    // far more than the pool
      send_word(make_word(CMD_FREE, 0, 32, 1'b1));           // null pointer
      send_word(make_word(CMD_FREE, 0, 8192, 1'b0));         // first offset past the pool
      send_word(make_word(CMD_FREE, 16'hFFFF, 16'hFFFF, 1'b0));
      send_word(make_word(CMD_FREE, 0, 32, 1'b0));
      send_word(make_word(CMD_FREE, 0, 32, 1'b0));           // already free
      send_word(make_word(CMD_FREE, 0, 96, 1'b0));           // inside a run
      send_word(make_word(2'd3, 16'hFFFF, 16'hFFFF, 1'b1));  // unused command
      send_word(make_word(CMD_ALLOC, 1, 0, 1'b0));
      send_word(make_word(CMD_CLEAR, 0, 0, 1'b0));
      send_word(make_word(CMD_ALLOC, NUM_BLOCKS * BLOCK_BYTES, 0, 1'b0));  // whole pool
      send_word(make_word(CMD_ALLOC, 1, 0, 1'b0));           // no room
      send_word(make_word(CMD_FREE, 0, 8191, 1'b0));         // last block, inside run
      send_word(make_word(CMD_ALLOC, NUM_BLOCKS * BLOCK_BYTES + 1, 0, 1'b0));
      send_word(make_word(CMD_FREE, 0, 0, 1'b0));
      send_word(make_word(CMD_ALLOC, (NUM_BLOCKS - 1) * BLOCK_BYTES, 0, 1'b0));
      send_word(make_word(CMD_ALLOC, BLOCK_BYTES, 0, 1'b0)); // highest offset
      send_word(make_word(CMD_FREE, 0, 8191, 1'b0));
      send_word(make_word(2'd3, 0, 0, 1'b0));
      send_word(make_word(CMD_CLEAR, 0, 0, 1'b0));
   endtask

   // Mostly allocs and frees of live runs; some null, stray and inner frees, clears and unused commands
   task automatic run_random(input int count);
      req_word_type w;
      int pick, sel, start, k0;
      for (int n = 0; n < count; n++) begin
         w.command     = CMD_ALLOC;
         w.size_bytes  = SIZE_W'($urandom);
         w.free_offset = OFS_W'($urandom);
         w.free_null   = 1'($urandom_range(0, 1));
         pick  = $urandom_range(0, 99);
         start = -1;
         if (pick >= 55 && pick < 95) begin
            k0 = $urandom_range(0, NUM_BLOCKS - 1);
            for (int k = 0; k < NUM_BLOCKS; k++) begin
               if (sb.live_start[(k0 + k) % NUM_BLOCKS]) begin
                  start = (k0 + k) % NUM_BLOCKS;
                  break;
               end
            end
         end
         if (pick < 55 || (pick < 95 && start < 0)) begin
            sel = $urandom_range(0, 99);
            if (sel < 3)       w.size_bytes = '0;
            else if (sel < 83) w.size_bytes = SIZE_W'($urandom_range(1, 160));
            else if (sel < 95) w.size_bytes = SIZE_W'($urandom_range(161, 2048));
         end else if (pick < 85) begin
            w.command     = CMD_FREE;
            w.free_offset = OFS_W'(start * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1));
            w.free_null   = 1'b0;
         end else if (pick < 89) begin
            w.command     = CMD_FREE;
            w.free_offset = OFS_W'(((start + 1) % NUM_BLOCKS) * BLOCK_BYTES);
            w.free_null   = 1'b0;
         end else if (pick < 95) begin
            w.command     = CMD_FREE;
            w.free_offset = OFS_W'(start * BLOCK_BYTES);
            w.free_null   = 1'b1;
         end else if (pick < 97) begin
            w.command = CMD_FREE;
         end else if (pick < 98) begin
            w.command = CMD_CLEAR;
         end else begin
            w.command = 2'd3;
         end
         send_word(w);
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(RANDOM_WORDS);
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain outstanding responses, then watch for strays
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
